// ===== design/assert_macros.svh =====
// Assertion macros shared by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CSV_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define CSV_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define CSV_ASSERT(name, clk, rst_n, prop)
`define CSV_ASSERT_IMP(name, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/csv_tok_pkg.sv =====
// Types, constants and the per-byte parse function of the CSV tokenizer.
package csv_tok_pkg;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] DELIM_RESET = 8'd44;
  localparam logic [7:0] QUOTE_RESET = 8'd34;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_PLAIN  = 2'd1,
    MODE_QUOTED = 2'd2,
    MODE_QSEEN  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_EOF  = 1'b1
  } action_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       quoted;
    logic       rec_end;
    logic       last;
  } res_t;

  typedef struct packed {
    mode_e      mode;
    logic [1:0] cnt;
    logic       rec_clr;
    res_t       r0;
    res_t       r1;
  } tb_t;

  function automatic res_t mk_data(input logic [7:0] c);
    res_t r;
    r = '0;
    r.kind = KIND_DATA;
    r.data = c;
    return r;
  endfunction

  function automatic res_t mk_end(input logic quoted, input logic rec_end);
    res_t r;
    r = '0;
    r.kind = KIND_END;
    r.quoted = quoted;
    r.rec_end = rec_end;
    return r;
  endfunction

  function automatic res_t mk_err();
    res_t r;
    r = '0;
    r.kind = KIND_ERR;
    return r;
  endfunction

  // One byte through the field state machine; gives up to two results.
  function automatic tb_t take_byte(input mode_e mode, input logic [7:0] c,
                                    input logic [7:0] delim, input logic [7:0] quote);
    tb_t t;
    t = '0;
    t.mode = mode;
    case (mode)
      MODE_START: begin
        if (c == CH_LF) begin
          t.r0 = mk_end(1'b0, 1'b1);
          t.cnt = 2'd1;
          t.rec_clr = 1'b1;
          t.mode = MODE_START;
        end else if (c == quote) begin
          t.mode = MODE_QUOTED;
        end else if (c == delim) begin
          t.r0 = mk_end(1'b0, 1'b0);
          t.cnt = 2'd1;
          t.mode = MODE_START;
        end else begin
          t.r0 = mk_data(c);
          t.cnt = 2'd1;
          t.mode = MODE_PLAIN;
        end
      end
      MODE_PLAIN: begin
        if (c == CH_LF) begin
          t.r0 = mk_end(1'b0, 1'b1);
          t.cnt = 2'd1;
          t.rec_clr = 1'b1;
          t.mode = MODE_START;
        end else if (c != quote && c == delim) begin
          t.r0 = mk_end(1'b0, 1'b0);
          t.cnt = 2'd1;
          t.mode = MODE_START;
        end else begin
          t.r0 = mk_data(c);
          t.cnt = 2'd1;
        end
      end
      MODE_QUOTED: begin
        if (c == quote) begin
          t.mode = MODE_QSEEN;
        end else begin
          t.r0 = mk_data(c);
          t.cnt = 2'd1;
        end
      end
      MODE_QSEEN: begin
        if (c == CH_LF) begin
          t.r0 = mk_end(1'b1, 1'b1);
          t.cnt = 2'd1;
          t.rec_clr = 1'b1;
          t.mode = MODE_START;
        end else if (c == quote) begin
          t.r0 = mk_data(c);
          t.cnt = 2'd1;
          t.mode = MODE_QUOTED;
        end else if (c == delim) begin
          t.r0 = mk_end(1'b1, 1'b0);
          t.cnt = 2'd1;
          t.mode = MODE_START;
        end else begin
          t.r0 = mk_end(1'b1, 1'b0);
          t.r1 = mk_data(c);
          t.cnt = 2'd2;
          t.mode = MODE_PLAIN;
        end
      end
      default: begin
        t.mode = MODE_START;
      end
    endcase
    return t;
  endfunction

endpackage

// ===== design/csv_record_tokenizer_core.sv =====
// Top level of the CSV record tokenizer: input register, parse logic, result buffer.
// A byte is held in the input register, then its results in the result buffer.
// Throughput: one input byte per cycle while out_stall_i is low and each byte gives
// at most one result; otherwise the next byte waits until the last result is taken.
// Reset clears parse state, buffers and restores delimiter 44 and quote 34.
`include "assert_macros.svh"
module csv_record_tokenizer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [7:0]  text_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic        field_quoted_o,
  output logic        record_end_o,
  output logic        last_o
);
  import csv_tok_pkg::*;

  logic [7:0] delim_q, quote_q;
  logic       in_valid_q;
  action_e    action_q;
  logic [7:0] byte_q;
  mode_e      mode_q, mode_d;
  logic       cr_q, cr_d;
  logic       rs_q, rs_d;
  res_t       res_q [3];
  logic [1:0] cnt_q;
  res_t       res_d [3];
  logic [1:0] cnt_d;
  logic       out_xfer, buf_free, proc, in_load;
  tb_t        ta, tb;
  logic       use_a, use_b;
  logic [1:0] ca, cb;
  logic [2:0] sum;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {24'd0, quote_q} : {24'd0, delim_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= DELIM_RESET;
      quote_q <= QUOTE_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        quote_q <= pwdata[7:0];
      end else begin
        delim_q <= pwdata[7:0];
      end
    end
  end

  assign out_xfer = out_valid_o && !out_stall_i;
  assign buf_free = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_xfer);
  assign proc = in_valid_q && buf_free;
  assign in_stall_o = in_valid_q && !buf_free;
  assign in_load = !in_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      action_q <= action_e'(action_i);
      byte_q <= text_byte_i;
    end
  end

  always_comb begin
    ta = take_byte(mode_q, (cr_q && byte_q != CH_LF) ? CH_CR : byte_q, delim_q, quote_q);
    tb = take_byte(ta.mode, byte_q, delim_q, quote_q);
    use_a = !(!cr_q && byte_q == CH_CR);
    use_b = cr_q && byte_q != CH_LF && byte_q != CH_CR;
    ca = use_a ? ta.cnt : 2'd0;
    cb = use_b ? tb.cnt : 2'd0;
    res_d[0] = '0;
    res_d[1] = '0;
    res_d[2] = '0;
    cnt_d = 2'd0;
    sum = 3'd0;
    if (action_q == ACT_EOF) begin
      mode_d = MODE_START;
      cr_d = 1'b0;
      rs_d = 1'b0;
      case (mode_q)
        MODE_QUOTED: begin
          res_d[0] = mk_err();
          cnt_d = 2'd1;
        end
        MODE_PLAIN: begin
          res_d[0] = mk_end(1'b0, 1'b1);
          cnt_d = 2'd1;
        end
        MODE_QSEEN: begin
          res_d[0] = mk_end(1'b1, 1'b1);
          cnt_d = 2'd1;
        end
        default: begin
          if (rs_q) begin
            res_d[0] = mk_end(1'b0, 1'b1);
            cnt_d = 2'd1;
          end
        end
      endcase
    end else begin
      cr_d = (byte_q == CH_CR);
      mode_d = use_b ? tb.mode : (use_a ? ta.mode : mode_q);
      rs_d = !((use_a && ta.rec_clr) || (use_b && tb.rec_clr));
      case (ca)
        2'd0: begin
          res_d[0] = tb.r0;
          res_d[1] = tb.r1;
        end
        2'd1: begin
          res_d[0] = ta.r0;
          res_d[1] = tb.r0;
          res_d[2] = tb.r1;
        end
        default: begin
          res_d[0] = ta.r0;
          res_d[1] = ta.r1;
          res_d[2] = tb.r0;
        end
      endcase
      sum = {1'b0, ca} + {1'b0, cb};
      cnt_d = sum[1:0];
    end
    res_d[0].last = (cnt_d == 2'd1);
    res_d[1].last = (cnt_d == 2'd2);
    res_d[2].last = (cnt_d == 2'd3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_START;
      cr_q <= 1'b0;
      rs_q <= 1'b0;
      cnt_q <= 2'd0;
    end else if (proc) begin
      mode_q <= mode_d;
      cr_q <= cr_d;
      rs_q <= rs_d;
      cnt_q <= cnt_d;
    end else if (out_xfer) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      res_q <= res_d;
    end else if (out_xfer) begin
      res_q[0] <= res_q[1];
      res_q[1] <= res_q[2];
    end
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign kind_o = res_q[0].kind;
  assign data_byte_o = res_q[0].data;
  assign field_quoted_o = res_q[0].quoted;
  assign record_end_o = res_q[0].rec_end;
  assign last_o = res_q[0].last;

  `CSV_ASSERT_IMP(a_stall_needs_item, clk_i, rst_ni, in_stall_o, in_valid_q)
  `CSV_ASSERT_IMP(a_more_not_last, clk_i, rst_ni, cnt_q > 2'd1, !res_q[0].last)
  `CSV_ASSERT_IMP(a_single_is_last, clk_i, rst_ni, cnt_q == 2'd1, res_q[0].last)
  `CSV_ASSERT_IMP(a_marker_no_data, clk_i, rst_ni, out_valid_o && kind_o != KIND_DATA, data_byte_o == 8'd0)
  `CSV_ASSERT_IMP(a_cr_not_after_eof, clk_i, rst_ni, proc && action_q == ACT_EOF, ##1 (!cr_q && mode_q == MODE_START))

endmodule
